[sv/suffix_array_lcp_match_counter_core_assert.svh]
// Assertion macros used by salmc_checker.
`ifndef SUFFIX_ARRAY_LCP_MATCH_COUNTER_CORE_ASSERT_SVH
`define SUFFIX_ARRAY_LCP_MATCH_COUNTER_CORE_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define SALMC_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("salmc assertion failed");

// Next-cycle implication, masked during reset.
`define SALMC_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("salmc assertion failed");

// Next-cycle implication that also covers the reset cycles.
`define SALMC_ASSERT_RST(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error("salmc assertion failed");

`endif

[sv/salmc_pkg.sv]
package salmc_pkg;

    localparam int FIELD_W   = 14;
    localparam int CODE_W    = 15;
    localparam int CODE_SPAN = (1 << FIELD_W) + 2;

    localparam logic [CODE_W-1:0] CODE_OFS  = CODE_W'(2);
    localparam logic [CODE_W-1:0] CODE_SEP  = CODE_W'(1);
    localparam logic [CODE_W-1:0] CODE_TERM = CODE_W'(0);

    typedef enum logic [5:0] {
        ST_IDLE,
        ST_SEP,
        ST_TERM,
        ST_INIT,
        ST_CLR,
        ST_CNT_A,
        ST_CNT_B,
        ST_CNT_C,
        ST_CNT_D,
        ST_PFX_A,
        ST_PFX_B,
        ST_PLC_A,
        ST_PLC_B,
        ST_PLC_C,
        ST_PLC_D,
        ST_RK0_A,
        ST_RK0_B,
        ST_RK0_C,
        ST_LOOP_CHK,
        ST_SH_TAIL,
        ST_SH_A,
        ST_SH_B,
        ST_RR_A,
        ST_RR_B,
        ST_RR_C,
        ST_CP_A,
        ST_CP_B,
        ST_LC_A,
        ST_LC_B,
        ST_LC_C,
        ST_LC_CHK,
        ST_LC_CMP,
        ST_LC_WR,
        ST_LF_A,
        ST_LF_B,
        ST_RB_A,
        ST_RB_B,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic i_last;
        logic span_last;
        logic i_zero;
        logic rank_zero;
        logic loop_go;
        logic lc_inb;
        logic lc_eq;
        logic pass0;
        logic out_busy;
    } dp_stat_t;

endpackage

[sv/suffix_array_lcp_match_counter_core.sv]
// Suffix-array match counter.
// Input channel (s_*): one symbol item per cycle while loading. Items with
// s_in_second_string low belong to string A, high to string B. The item with
// s_last high ends the load and starts the computation.
// Config channel (cfg_*): always ready; writes target_length. Write it only
// while the block is idle.
// Result channel (m_*): one match_count item per last item, none otherwise.
// After the last item the block drops s_ready and runs from its
// single-port-write memories, n being the joined length (A + B + 2):
//   initial code sort and ranking
//   doubling rounds, at most ceil(log2(n)) of them
//   LCP walk
//   match walks
// The bucket clear and prefix sweeps of the first sort dominate short strings.
// The result sits in an output register; the block returns to idle (s_ready
// high) as soon as it is loaded. If the previous result is still unread when
// a computation ends, the block waits in its final step until m_ready takes it.
// Reset (aresetn low, synchronous) empties the string, clears target_length
// and drops m_valid; no memory clearing pass is needed.
module suffix_array_lcp_match_counter_core
    import salmc_pkg::*;
#(
    parameter int MAX_TOTAL = 8192
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [FIELD_W-1:0] s_symbol,
    input  logic               s_in_second_string,
    input  logic               s_last,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [FIELD_W-1:0] cfg_data,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [FIELD_W-1:0] m_match_count
);

    state_t   cmd;
    dp_stat_t st;
    logic     s_fire;
    logic     cfg_fire;

    assign cfg_ready = 1'b1;
    assign s_fire    = s_valid && s_ready;
    assign cfg_fire  = cfg_valid && cfg_ready;

    // sequencer: walks the sort, rank, LCP and match phases
    salmc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_fire  (s_fire),
        .s_last  (s_last),
        .st      (st),
        .cmd     (cmd),
        .s_ready (s_ready)
    );

    // memories, counters and compare logic
    salmc_dpath #(
        .MAX_TOTAL (MAX_TOTAL)
    ) u_dpath (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .s_fire             (s_fire),
        .s_symbol           (s_symbol),
        .s_in_second_string (s_in_second_string),
        .s_last             (s_last),
        .cfg_fire           (cfg_fire),
        .cfg_data           (cfg_data),
        .m_ready            (m_ready),
        .m_valid            (m_valid),
        .m_match_count      (m_match_count),
        .st                 (st)
    );

endmodule

[sv/salmc_ctrl.sv]
module salmc_ctrl
    import salmc_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_fire,
    input  logic     s_last,
    input  dp_stat_t st,
    output state_t   cmd,
    output logic     s_ready
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = state_reg;
        s_ready    = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE:     if (s_fire && s_last) state_next = ST_SEP;
            ST_SEP:      state_next = ST_TERM;
            ST_TERM:     state_next = ST_INIT;
            ST_INIT:     if (st.i_last) state_next = ST_CLR;
            ST_CLR:      if (st.span_last) state_next = ST_CNT_A;
            ST_CNT_A:    state_next = ST_CNT_B;
            ST_CNT_B:    state_next = ST_CNT_C;
            ST_CNT_C:    state_next = ST_CNT_D;
            ST_CNT_D:    state_next = st.i_last ? ST_PFX_A : ST_CNT_A;
            ST_PFX_A:    state_next = ST_PFX_B;
            ST_PFX_B:    state_next = st.span_last ? ST_PLC_A : ST_PFX_A;
            ST_PLC_A:    state_next = ST_PLC_B;
            ST_PLC_B:    state_next = ST_PLC_C;
            ST_PLC_C:    state_next = ST_PLC_D;
            ST_PLC_D: begin
                if (st.i_last) state_next = st.pass0 ? ST_RK0_A : ST_RR_A;
                else           state_next = ST_PLC_A;
            end
            ST_RK0_A:    state_next = ST_RK0_B;
            ST_RK0_B:    state_next = ST_RK0_C;
            ST_RK0_C:    state_next = st.i_last ? ST_LOOP_CHK : ST_RK0_A;
            ST_LOOP_CHK: state_next = st.loop_go ? ST_SH_TAIL : ST_LC_A;
            ST_SH_TAIL:  if (st.i_last) state_next = ST_SH_A;
            ST_SH_A:     state_next = ST_SH_B;
            ST_SH_B:     state_next = st.i_last ? ST_CLR : ST_SH_A;
            ST_RR_A:     state_next = ST_RR_B;
            ST_RR_B:     state_next = ST_RR_C;
            ST_RR_C:     state_next = st.i_last ? ST_CP_A : ST_RR_A;
            ST_CP_A:     state_next = ST_CP_B;
            ST_CP_B:     state_next = st.i_last ? ST_LOOP_CHK : ST_CP_A;
            ST_LC_A:     state_next = ST_LC_B;
            ST_LC_B: begin
                if (st.rank_zero) state_next = st.i_last ? ST_LF_A : ST_LC_A;
                else              state_next = ST_LC_C;
            end
            ST_LC_C:     state_next = ST_LC_CHK;
            ST_LC_CHK:   state_next = st.lc_inb ? ST_LC_CMP : ST_LC_WR;
            ST_LC_CMP:   state_next = st.lc_eq ? ST_LC_CHK : ST_LC_WR;
            ST_LC_WR:    state_next = st.i_last ? ST_LF_A : ST_LC_A;
            ST_LF_A:     state_next = ST_LF_B;
            ST_LF_B:     state_next = st.i_last ? ST_RB_A : ST_LF_A;
            ST_RB_A:     state_next = ST_RB_B;
            ST_RB_B:     state_next = st.i_zero ? ST_DONE : ST_RB_A;
            ST_DONE:     if (!st.out_busy) state_next = ST_IDLE;
            default:     state_next = ST_IDLE;
        endcase
    end

endmodule

[sv/salmc_dpath.sv]
module salmc_dpath
    import salmc_pkg::*;
#(
    parameter int MAX_TOTAL = 8192
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  state_t             cmd,
    input  logic               s_fire,
    input  logic [FIELD_W-1:0] s_symbol,
    input  logic               s_in_second_string,
    input  logic               s_last,
    input  logic               cfg_fire,
    input  logic [FIELD_W-1:0] cfg_data,
    input  logic               m_ready,
    output logic               m_valid,
    output logic [FIELD_W-1:0] m_match_count,
    output dp_stat_t           st
);

    localparam int IW        = $clog2(MAX_TOTAL);
    localparam int NW        = $clog2(MAX_TOTAL + 1);
    localparam int BKT_DEPTH = (CODE_SPAN > MAX_TOTAL) ? CODE_SPAN : MAX_TOTAL;
    localparam int BW        = $clog2(BKT_DEPTH);
    localparam int CW        = (BW > NW) ? BW : NW;
    localparam int CMPW      = (IW > FIELD_W) ? IW : FIELD_W;

    // memories
    logic [CODE_W-1:0] code_mem [MAX_TOTAL];
    logic [IW-1:0]     sa_mem   [MAX_TOTAL];
    logic [IW-1:0]     san_mem  [MAX_TOTAL];
    logic [IW-1:0]     rk_mem   [MAX_TOTAL];
    logic [IW-1:0]     rkn_mem  [MAX_TOTAL];
    logic [IW-1:0]     lcp_mem  [MAX_TOTAL];
    logic [IW-1:0]     left_mem [MAX_TOTAL];
    logic [NW-1:0]     bkt_mem  [BKT_DEPTH];

    logic [CODE_W-1:0] code_qa_reg, code_qb_reg;
    logic [IW-1:0]     sa_q_reg, san_q_reg, rk_qa_reg, rk_qb_reg, rkn_q_reg;
    logic [IW-1:0]     lcp_q_reg, left_q_reg;
    logic [NW-1:0]     bkt_q_reg;

    logic              code_we, sa_we, san_we, rk_we, rkn_we, lcp_we, left_we, bkt_we;
    logic [IW-1:0]     code_wa, code_ra, code_rb, sa_wa, sa_ra, san_wa, san_ra;
    logic [IW-1:0]     rk_wa, rk_ra, rk_rb, rkn_wa, rkn_ra, lcp_wa, lcp_ra;
    logic [IW-1:0]     left_wa, left_ra;
    logic [BW-1:0]     bkt_wa, bkt_ra;
    logic [CODE_W-1:0] code_wd;
    logic [IW-1:0]     sa_wd, san_wd, rk_wd, rkn_wd, lcp_wd, left_wd;
    logic [NW-1:0]     bkt_wd;

    // datapath registers
    logic [CW-1:0]      i_reg;
    logic [IW-1:0]      t_reg, h_reg, r_reg, j_reg, src_reg, a_reg, rank_reg;
    logic [NW:0]        k_reg;
    logic [BW-1:0]      key_reg;
    logic [NW-1:0]      sum_reg, cnt_reg, la_reg, tot_reg, n_reg, prev_sk_reg;
    logic [CODE_W-1:0]  prev_code_reg;
    logic [IW-1:0]      prev_rk_reg, prev_sa_reg, prev_left_reg;
    logic [IW-1:0]      nxt_sa_reg, nxt_lcp_reg, nxt_right_reg;
    logic               pass0_reg, m_valid_reg;
    logic [FIELD_W-1:0] target_reg, m_count_reg;

    // derived values
    logic [NW-1:0]     n_m1, tot_next, sk_cur;
    logic [IW-1:0]     i_idx, rank_new0, rank_new, lv, rv, best;
    logic [CW-1:0]     i_step;
    logic [BW-1:0]     key_c;
    logic [IW:0]       ih, jh;
    logic              store_ok, differ, sa_in_a, hit;

    assign n_m1   = n_reg - NW'(1);
    assign i_idx  = i_reg[IW-1:0];
    assign i_step = st.i_last ? '0 : i_reg + CW'(1);
    assign key_c  = pass0_reg ? BW'(code_qa_reg) : BW'(rk_qa_reg);
    assign ih     = (IW+1)'(i_idx) + (IW+1)'(h_reg);
    assign jh     = (IW+1)'(j_reg) + (IW+1)'(h_reg);

    // A symbols only before any B symbol; room kept for separator and terminator
    assign store_ok = ((NW+2)'(tot_reg) + (NW+2)'(3) <= (NW+2)'(MAX_TOTAL)) &&
                      (s_in_second_string || (tot_reg == la_reg));
    assign tot_next = tot_reg + NW'(store_ok);

    assign rank_new0 = st.i_zero ? '0 : rank_reg + IW'(code_qa_reg != prev_code_reg);
    assign sk_cur    = ((NW+2)'(a_reg) + (NW+2)'(k_reg) < (NW+2)'(n_reg)) ?
                       NW'(rk_qb_reg) + NW'(1) : '0;
    assign differ    = (rk_qa_reg != prev_rk_reg) || (sk_cur != prev_sk_reg);
    assign rank_new  = st.i_zero ? '0 : rank_reg + IW'(differ);

    assign sa_in_a = NW'(sa_q_reg) < la_reg;
    always_comb begin
        if (st.i_zero || !sa_in_a)              lv = '0;
        else if (NW'(prev_sa_reg) > la_reg)     lv = lcp_q_reg;
        else if (prev_left_reg < lcp_q_reg)     lv = prev_left_reg;
        else                                    lv = lcp_q_reg;
        if (st.i_last || !sa_in_a)              rv = '0;
        else if (NW'(nxt_sa_reg) > la_reg)      rv = nxt_lcp_reg;
        else if (nxt_right_reg < nxt_lcp_reg)   rv = nxt_right_reg;
        else                                    rv = nxt_lcp_reg;
    end
    assign best = (left_q_reg > rv) ? left_q_reg : rv;
    assign hit  = sa_in_a && (CMPW'(best) == CMPW'(target_reg));

    assign st.i_last    = (i_reg == CW'(n_m1));
    assign st.span_last = pass0_reg ? (i_reg == CW'(CODE_SPAN - 1)) : st.i_last;
    assign st.i_zero    = (i_reg == '0);
    assign st.rank_zero = (rk_qa_reg == '0);
    assign st.loop_go   = (k_reg < (NW+1)'(n_reg)) && (NW'(rank_reg) != n_m1);
    assign st.lc_inb    = (ih < (IW+1)'(n_reg)) && (jh < (IW+1)'(n_reg));
    assign st.lc_eq     = (code_qa_reg == code_qb_reg);
    assign st.pass0     = pass0_reg;
    assign st.out_busy  = m_valid_reg;

    assign m_valid       = m_valid_reg;
    assign m_match_count = m_count_reg;

    // memory port control
    always_comb begin
        code_we = 1'b0; code_wa = '0; code_wd = '0; code_ra = '0; code_rb = '0;
        sa_we   = 1'b0; sa_wa   = '0; sa_wd   = '0; sa_ra   = '0;
        san_we  = 1'b0; san_wa  = '0; san_wd  = '0; san_ra  = '0;
        rk_we   = 1'b0; rk_wa   = '0; rk_wd   = '0; rk_ra   = '0; rk_rb = '0;
        rkn_we  = 1'b0; rkn_wa  = '0; rkn_wd  = '0; rkn_ra  = '0;
        lcp_we  = 1'b0; lcp_wa  = '0; lcp_wd  = '0; lcp_ra  = '0;
        left_we = 1'b0; left_wa = '0; left_wd = '0; left_ra = '0;
        bkt_we  = 1'b0; bkt_wa  = '0; bkt_wd  = '0; bkt_ra  = '0;
        unique case (cmd) inside
            ST_IDLE: begin
                if (s_fire && store_ok) begin
                    code_we = 1'b1;
                    code_wa = s_in_second_string ? IW'(tot_reg + NW'(1)) : IW'(la_reg);
                    code_wd = CODE_W'(s_symbol) + CODE_OFS;
                end
            end
            ST_SEP: begin
                code_we = 1'b1; code_wa = IW'(la_reg); code_wd = CODE_SEP;
            end
            ST_TERM: begin
                code_we = 1'b1; code_wa = IW'(n_m1); code_wd = CODE_TERM;
            end
            ST_INIT: begin
                san_we = 1'b1; san_wa = i_idx; san_wd = i_idx;
            end
            ST_CLR: begin
                bkt_we = 1'b1; bkt_wa = i_reg[BW-1:0]; bkt_wd = '0;
            end
            ST_CNT_A, ST_PLC_A: san_ra = i_idx;
            ST_CNT_B, ST_PLC_B: begin
                code_ra = san_q_reg; rk_ra = san_q_reg;
            end
            ST_CNT_C, ST_PLC_C: bkt_ra = key_c;
            ST_CNT_D: begin
                bkt_we = 1'b1; bkt_wa = key_reg; bkt_wd = bkt_q_reg + NW'(1);
            end
            ST_PFX_A: bkt_ra = i_reg[BW-1:0];
            ST_PFX_B: begin
                bkt_we = 1'b1; bkt_wa = i_reg[BW-1:0]; bkt_wd = sum_reg;
            end
            ST_PLC_D: begin
                sa_we  = 1'b1; sa_wa = bkt_q_reg[IW-1:0]; sa_wd = src_reg;
                bkt_we = 1'b1; bkt_wa = key_reg; bkt_wd = bkt_q_reg + NW'(1);
            end
            ST_RK0_A, ST_SH_A, ST_RR_A: sa_ra = i_idx;
            ST_RK0_B: code_ra = sa_q_reg;
            ST_RK0_C: begin
                rk_we = 1'b1; rk_wa = a_reg; rk_wd = rank_new0;
            end
            ST_SH_TAIL: begin
                san_we = 1'b1; san_wa = t_reg; san_wd = i_idx;
            end
            ST_SH_B: begin
                if ((NW+1)'(sa_q_reg) >= k_reg) begin
                    san_we = 1'b1; san_wa = t_reg; san_wd = sa_q_reg - IW'(k_reg);
                end
            end
            ST_RR_B: begin
                rk_ra = sa_q_reg;
                rk_rb = IW'((NW+2)'(sa_q_reg) + (NW+2)'(k_reg));
            end
            ST_RR_C: begin
                rkn_we = 1'b1; rkn_wa = a_reg; rkn_wd = rank_new;
            end
            ST_CP_A: rkn_ra = i_idx;
            ST_CP_B: begin
                rk_we = 1'b1; rk_wa = i_idx; rk_wd = rkn_q_reg;
            end
            ST_LC_A: rk_ra = i_idx;
            ST_LC_B: begin
                if (st.rank_zero) begin
                    lcp_we = 1'b1; lcp_wa = '0; lcp_wd = '0;
                end else begin
                    sa_ra = rk_qa_reg - IW'(1);
                end
            end
            ST_LC_CHK: begin
                code_ra = ih[IW-1:0]; code_rb = jh[IW-1:0];
            end
            ST_LC_WR: begin
                lcp_we = 1'b1; lcp_wa = r_reg; lcp_wd = h_reg;
            end
            ST_LF_A: begin
                sa_ra = i_idx; lcp_ra = i_idx;
            end
            ST_LF_B: begin
                left_we = 1'b1; left_wa = i_idx; left_wd = lv;
            end
            ST_RB_A: begin
                sa_ra = i_idx; lcp_ra = i_idx; left_ra = i_idx;
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (code_we) code_mem[code_wa] <= code_wd;
        code_qa_reg <= code_mem[code_ra];
        code_qb_reg <= code_mem[code_rb];
    end

    always_ff @(posedge aclk) begin
        if (sa_we) sa_mem[sa_wa] <= sa_wd;
        sa_q_reg <= sa_mem[sa_ra];
    end

    always_ff @(posedge aclk) begin
        if (san_we) san_mem[san_wa] <= san_wd;
        san_q_reg <= san_mem[san_ra];
    end

    always_ff @(posedge aclk) begin
        if (rk_we) rk_mem[rk_wa] <= rk_wd;
        rk_qa_reg <= rk_mem[rk_ra];
        rk_qb_reg <= rk_mem[rk_rb];
    end

    always_ff @(posedge aclk) begin
        if (rkn_we) rkn_mem[rkn_wa] <= rkn_wd;
        rkn_q_reg <= rkn_mem[rkn_ra];
    end

    always_ff @(posedge aclk) begin
        if (lcp_we) lcp_mem[lcp_wa] <= lcp_wd;
        lcp_q_reg <= lcp_mem[lcp_ra];
    end

    always_ff @(posedge aclk) begin
        if (left_we) left_mem[left_wa] <= left_wd;
        left_q_reg <= left_mem[left_ra];
    end

    always_ff @(posedge aclk) begin
        if (bkt_we) bkt_mem[bkt_wa] <= bkt_wd;
        bkt_q_reg <= bkt_mem[bkt_ra];
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            la_reg      <= '0;
            tot_reg     <= '0;
            pass0_reg   <= 1'b0;
            target_reg  <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_fire) target_reg <= cfg_data;
            if (m_valid_reg && m_ready) m_valid_reg <= 1'b0;
            unique case (cmd)
                ST_IDLE: begin
                    if (s_fire) begin
                        tot_reg <= tot_next;
                        if (store_ok && !s_in_second_string) la_reg <= la_reg + NW'(1);
                    end
                end
                ST_SEP:   pass0_reg <= 1'b1;
                ST_RK0_C: if (st.i_last) pass0_reg <= 1'b0;
                ST_DONE: begin
                    if (!m_valid_reg) begin
                        m_valid_reg <= 1'b1;
                        la_reg      <= '0;
                        tot_reg     <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // working registers
    always_ff @(posedge aclk) begin
        unique case (cmd) inside
            ST_IDLE:  if (s_fire && s_last) n_reg <= tot_next + NW'(2);
            ST_TERM:  i_reg <= '0;
            ST_INIT:  i_reg <= i_step;
            ST_CLR:   i_reg <= st.span_last ? '0 : i_reg + CW'(1);
            ST_CNT_B, ST_PLC_B: src_reg <= san_q_reg;
            ST_CNT_C, ST_PLC_C: key_reg <= key_c;
            ST_CNT_D: begin
                i_reg <= i_step;
                if (st.i_last) sum_reg <= '0;
            end
            ST_PFX_B: begin
                sum_reg <= sum_reg + bkt_q_reg;
                i_reg   <= st.span_last ? '0 : i_reg + CW'(1);
            end
            ST_PLC_D: i_reg <= i_step;
            ST_RK0_B, ST_RR_B: a_reg <= sa_q_reg;
            ST_RK0_C: begin
                rank_reg      <= rank_new0;
                prev_code_reg <= code_qa_reg;
                i_reg         <= i_step;
                if (st.i_last) k_reg <= (NW+1)'(1);
            end
            ST_LOOP_CHK: begin
                if (st.loop_go) begin
                    i_reg <= CW'((NW+1)'(n_reg) - k_reg);
                    t_reg <= '0;
                end else begin
                    i_reg <= '0;
                    h_reg <= '0;
                end
            end
            ST_SH_TAIL: begin
                t_reg <= t_reg + IW'(1);
                i_reg <= i_step;
            end
            ST_SH_B: begin
                if ((NW+1)'(sa_q_reg) >= k_reg) t_reg <= t_reg + IW'(1);
                i_reg <= i_step;
            end
            ST_RR_C: begin
                rank_reg    <= rank_new;
                prev_rk_reg <= rk_qa_reg;
                prev_sk_reg <= sk_cur;
                i_reg       <= i_step;
            end
            ST_CP_B: begin
                i_reg <= i_step;
                if (st.i_last) k_reg <= {k_reg[NW-1:0], 1'b0};
            end
            ST_LC_B: begin
                r_reg <= rk_qa_reg;
                if (st.rank_zero) begin
                    h_reg <= '0;
                    i_reg <= i_step;
                end
            end
            ST_LC_C:   j_reg <= sa_q_reg;
            ST_LC_CMP: if (st.lc_eq) h_reg <= h_reg + IW'(1);
            ST_LC_WR: begin
                h_reg <= (h_reg == '0) ? '0 : h_reg - IW'(1);
                i_reg <= i_step;
            end
            ST_LF_B: begin
                prev_left_reg <= lv;
                prev_sa_reg   <= sa_q_reg;
                if (st.i_last) begin
                    i_reg   <= CW'(n_m1);
                    cnt_reg <= '0;
                end else begin
                    i_reg <= i_reg + CW'(1);
                end
            end
            ST_RB_B: begin
                nxt_sa_reg    <= sa_q_reg;
                nxt_lcp_reg   <= lcp_q_reg;
                nxt_right_reg <= rv;
                if (hit) cnt_reg <= cnt_reg + NW'(1);
                if (!st.i_zero) i_reg <= i_reg - CW'(1);
            end
            ST_DONE: if (!m_valid_reg) m_count_reg <= FIELD_W'(cnt_reg);
            default: ;
        endcase
    end

endmodule

[sv/salmc_checker.sv]
`include "suffix_array_lcp_match_counter_core_assert.svh"

module salmc_checker
    import salmc_pkg::*;
(
    input logic               aclk,
    input logic               aresetn,
    input logic               s_valid,
    input logic               s_ready,
    input logic               s_last,
    input logic               m_valid,
    input logic               m_ready,
    input logic [FIELD_W-1:0] m_match_count
);

    // stalled result holds
    `SALMC_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_match_count))

    // a last item starts a computation: input closes next cycle
    `SALMC_ASSERT_NEXT(a_busy_after_last, s_valid && s_ready && s_last, !s_ready)

    // a result appears only as a computation ends, and the block reopens with it
    `SALMC_ASSERT_IMPL(a_result_end, $rose(m_valid), s_ready && !$past(s_ready))

    // reset drops the result
    `SALMC_ASSERT_RST(a_reset_clear, !aresetn, !m_valid)

endmodule

bind suffix_array_lcp_match_counter_core salmc_checker u_salmc_checker (.*);

[tb/sv/tb.sv]
`timescale 1ns / 1ps

module tb
    import salmc_pkg::*;
();

    // 5 ns half period, 10 ns clock
    localparam int HALF_PERIOD = 5;
    localparam int MAX_TOTAL   = 8192;
    localparam int RESET_CYCLES = 7;
    // idle cycles before a register write or the final verdict
    localparam int SETTLE_CYCLES = 64;
    // long receiver hold-off, longer than one full computation
    localparam int LONG_HOLD = 120000;
    localparam int RANDOM_ITEMS = 1800;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [FIELD_W-1:0] s_symbol;
    logic               s_in_second_string;
    logic               s_last;
    logic               cfg_valid;
    logic               cfg_ready;
    logic [FIELD_W-1:0] cfg_data;
    logic               m_valid;
    logic               m_ready;
    logic [FIELD_W-1:0] m_match_count;

    suffix_array_lcp_match_counter_core #(
        .MAX_TOTAL(MAX_TOTAL)
    ) dut (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_symbol          (s_symbol),
        .s_in_second_string(s_in_second_string),
        .s_last            (s_last),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_data          (cfg_data),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_match_count     (m_match_count)
    );

    // ---------------------------------------------------------------
    // Shadow of the block: loaded strings and the target register
    // ---------------------------------------------------------------
    logic [FIELD_W-1:0] target_len;
    int                 str_a[$];
    int                 str_b[$];
    logic [FIELD_W-1:0] pending_counts[$];

    int  mismatches;
    int  errors;
    bit  idle_en;
    bit  hold_req;
    int  hold_left;
    int  stall_left;

    initial aclk = 1'b0;
    always #HALF_PERIOD aclk = ~aclk;

    // Hard limit, far above the slowest correct run
    initial begin
        #600_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    // Count A suffixes whose longest common prefix with any B suffix
    // equals the target. The joined codes are A+2, separator 1, B+2,
    // terminator 0; the unique separator and terminator cut every match.
    function automatic logic [FIELD_W-1:0] count_target_matches();
        int codes[$];
        int la;
        int n;
        int best;
        int k;
        int hits;
        la = str_a.size();
        foreach (str_a[i]) codes.push_back(str_a[i] + 2);
        codes.push_back(1);
        foreach (str_b[i]) codes.push_back(str_b[i] + 2);
        codes.push_back(0);
        n = codes.size();
        hits = 0;
        for (int i = 0; i < la; i++) begin
            best = 0;
            for (int j = la + 1; j < n; j++) begin
                k = 0;
                while (codes[i + k] == codes[j + k]) k++;
                if (k > best) best = k;
            end
            if (best == int'(target_len)) hits++;
        end
        return FIELD_W'(hits);
    endfunction

    // Update the shadow for one accepted item
    task automatic absorb_item(input logic [FIELD_W-1:0] sym, input bit second,
                               input bit fin);
        if (str_a.size() + str_b.size() + 3 <= MAX_TOTAL) begin
            if (!second) begin
                // A symbols after B has started are dropped
                if (str_b.size() == 0) str_a.push_back(int'(sym));
            end else begin
                str_b.push_back(int'(sym));
            end
        end
        if (fin) begin
            pending_counts.push_back(count_target_matches());
            str_a.delete();
            str_b.delete();
        end
    endtask

    // ---------------------------------------------------------------
    // Sender: one item, valid held until accepted
    // ---------------------------------------------------------------
    task automatic send_item(input logic [FIELD_W-1:0] sym, input bit second,
                             input bit fin);
        int gap;
        if (idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 3);
            s_valid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid            = 1'b1;
        s_symbol           = sym;
        s_in_second_string = second;
        s_last             = fin;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        absorb_item(sym, second, fin);
        @(negedge aclk);
    endtask

    task automatic wait_results_drained();
        s_valid = 1'b0;
        while (pending_counts.size() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    // Register write, only with the block idle
    task automatic write_target(input logic [FIELD_W-1:0] value);
        wait_results_drained();
        cfg_valid = 1'b1;
        cfg_data  = value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        target_len = value;
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic send_pair(input int a_syms[$], input int b_syms[$]);
        foreach (a_syms[i])
            send_item(FIELD_W'(a_syms[i]), 1'b0,
                      (b_syms.size() == 0) && (i == a_syms.size() - 1));
        foreach (b_syms[i])
            send_item(FIELD_W'(b_syms[i]), 1'b1, i == b_syms.size() - 1);
    endtask

    function automatic int pick_symbol(input int mode);
        case (mode)
            0: return $urandom_range(0, 1);
            1: return $urandom_range(0, 3);
            2: return $urandom_range(9998, 10000);
            default: return $urandom_range(0, (1 << FIELD_W) - 1);
        endcase
    endfunction

    // ---------------------------------------------------------------
    // Receiver: random stalls plus an optional long hold-off
    // ---------------------------------------------------------------
    always @(negedge aclk) begin
        if (hold_req) begin
            hold_left = LONG_HOLD;
            hold_req  = 1'b0;
        end
        if (hold_left > 0) begin
            m_ready = 1'b0;
            hold_left--;
        end else if (!idle_en) begin
            m_ready = 1'b1;
        end else if (stall_left > 0) begin
            m_ready = 1'b0;
            stall_left--;
        end else if ($urandom_range(0, 4) == 0) begin
            m_ready    = 1'b0;
            stall_left = $urandom_range(0, 2);
        end else begin
            m_ready = 1'b1;
        end
    end

    // Result checker against the oldest expected count
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_counts.size() == 0) begin
                errors++;
                if (mismatches < 10)
                    $display("unexpected match_count item %0d", m_match_count);
                mismatches++;
            end else begin
                if (m_match_count !== pending_counts[0]) begin
                    errors++;
                    if (mismatches < 10)
                        $display("match_count mismatch: expected %0d actual %0d",
                                 pending_counts[0], m_match_count);
                    mismatches++;
                end
                void'(pending_counts.pop_front());
            end
        end
    end

    // ---------------------------------------------------------------
    // Tests
    // ---------------------------------------------------------------
    task automatic test_field_extremes();
        write_target(FIELD_W'(0));
        send_pair('{16383, 0}, '{10000});
        write_target(FIELD_W'(3));
        send_pair('{1, 2, 3}, '{1, 2, 3});
        send_pair('{0, 0, 0}, '{0, 0, 0, 0});
    endtask

    task automatic test_special_items();
        write_target(FIELD_W'(1));
        // last on an A symbol: B stays empty
        send_item(FIELD_W'(5), 1'b0, 1'b0);
        send_item(FIELD_W'(5), 1'b0, 1'b1);
        // A symbol after B is dropped
        send_item(FIELD_W'(2), 1'b0, 1'b0);
        send_item(FIELD_W'(2), 1'b1, 1'b0);
        send_item(FIELD_W'(7), 1'b0, 1'b0);
        send_item(FIELD_W'(2), 1'b1, 1'b1);
        // a lone B item ending an empty A
        send_item(FIELD_W'(4), 1'b1, 1'b1);
    endtask

    // Fill the store; overflow symbols are dropped, last still reports
    task automatic test_full_store();
        int a_len;
        a_len = MAX_TOTAL - 42;
        write_target(FIELD_W'(2));
        for (int i = 0; i < a_len; i++)
            send_item(FIELD_W'(pick_symbol(3)), 1'b0, 1'b0);
        for (int i = 0; i < 50; i++)
            send_item(FIELD_W'(pick_symbol(i < 45 ? 1 : 3)), 1'b1, i == 49);
    endtask

    task automatic test_random_strings(input int item_budget);
        int sent;
        int strings;
        int mode;
        int a_len;
        int b_len;
        int kind;
        logic [FIELD_W-1:0] tgt;
        sent = 0;
        strings = 0;
        while (sent < item_budget) begin
            if (strings % 6 == 0) begin
                case ($urandom_range(0, 7))
                    0: tgt = FIELD_W'(8192);
                    1: tgt = FIELD_W'(16383);
                    default: tgt = FIELD_W'($urandom_range(0, 6));
                endcase
                write_target(tgt);
            end
            mode  = $urandom_range(0, 3);
            a_len = $urandom_range(1, 40);
            b_len = $urandom_range(1, 40);
            kind  = $urandom_range(0, 9);
            for (int i = 0; i < a_len; i++) begin
                send_item(FIELD_W'(pick_symbol(mode)), 1'b0,
                          kind == 0 && i == a_len - 1);
                sent++;
            end
            if (kind != 0) begin
                for (int i = 0; i < b_len; i++) begin
                    // noise: stray A symbols and odd last placement
                    send_item(FIELD_W'(pick_symbol(mode)),
                              !(kind == 1 && $urandom_range(0, 3) == 0),
                              i == b_len - 1);
                    sent++;
                end
            end
            strings++;
        end
    endtask

    // Receiver holds off while the sender keeps offering; block stalls
    task automatic test_output_backpressure();
        write_target(FIELD_W'(1));
        hold_req = 1'b1;
        for (int r = 0; r < 3; r++)
            send_pair('{1, 0, 1}, '{0, 1, 1});
        // sender pauses until every count is back
        wait_results_drained();
    endtask

    initial begin
        aresetn            = 1'b0;
        s_valid            = 1'b0;
        s_symbol           = '0;
        s_in_second_string = 1'b0;
        s_last             = 1'b0;
        cfg_valid          = 1'b0;
        cfg_data           = '0;
        m_ready            = 1'b0;
        target_len         = '0;
        mismatches         = 0;
        errors             = 0;
        idle_en            = 1'b1;
        hold_req           = 1'b0;
        hold_left          = 0;
        stall_left         = 0;
        repeat (RESET_CYCLES) @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        test_field_extremes();
        test_special_items();
        test_output_backpressure();
        test_random_strings(RANDOM_ITEMS * 3 / 4);
        test_full_store();
        // closing stretch with no idling on either side
        idle_en = 1'b0;
        test_random_strings(RANDOM_ITEMS / 4);

        wait_results_drained();
        if (errors == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
